// ----- hw/rtl/nsr_pkg.sv -----
// Package for the Newton square root block: constants, control word type and microprogram.
`default_nettype none
package nsr_pkg;

	// default configuration
	localparam int MAX_ITER_DEF  = 32;
	localparam int FRAC_BITS_DEF = 16;

	// register and field widths
	localparam int TOL_W     = 16;
	localparam int DATA_W    = 32;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

	// status codes
	localparam logic STAT_CONVERGED = 1'b0;
	localparam logic STAT_LIMIT     = 1'b1;

	// microprogram addresses
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DIV_INIT = 3'd1,
		ST_DIV_STEP = 3'd2,
		ST_TEST     = 3'd3,
		ST_LIMIT    = 3'd4,
		ST_UPDATE   = 3'd5,
		ST_DONE_OK  = 3'd6,
		ST_DONE_LIM = 3'd7
	} step_t;

	// branch conditions
	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_NO_INPUT  = 3'd1,
		C_DIV_BUSY  = 3'd2,
		C_CONVERGED = 3'd3,
		C_AT_LIMIT  = 3'd4,
		C_OUT_BUSY  = 3'd5
	} cond_t;

	// one control word: datapath strobes plus a two-way branch
	typedef struct packed {
		logic  ld_item;
		logic  div_init;
		logic  div_step;
		logic  est_upd;
		logic  out_load;
		logic  stat;
		cond_t cond;
		step_t tgt;   // taken when cond holds
		step_t nxt;   // taken otherwise
	} ctrl_t;

	// microprogram ROM
	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t cw;
		cw = '{ld_item: 1'b0, div_init: 1'b0, div_step: 1'b0, est_upd: 1'b0,
			out_load: 1'b0, stat: STAT_CONVERGED, cond: C_ALWAYS,
			tgt: ST_IDLE, nxt: ST_IDLE};
		unique case (pc)
			ST_IDLE: begin
				cw.ld_item = 1'b1;
				cw.cond    = C_NO_INPUT;
				cw.tgt     = ST_IDLE;
				cw.nxt     = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cw.div_init = 1'b1;
				cw.tgt      = ST_DIV_STEP;
				cw.nxt      = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cw.div_step = 1'b1;
				cw.cond     = C_DIV_BUSY;
				cw.tgt      = ST_DIV_STEP;
				cw.nxt      = ST_TEST;
			end
			ST_TEST: begin
				cw.cond = C_CONVERGED;
				cw.tgt  = ST_DONE_OK;
				cw.nxt  = ST_LIMIT;
			end
			ST_LIMIT: begin
				cw.cond = C_AT_LIMIT;
				cw.tgt  = ST_DONE_LIM;
				cw.nxt  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cw.est_upd = 1'b1;
				cw.tgt     = ST_DIV_INIT;
				cw.nxt     = ST_DIV_INIT;
			end
			ST_DONE_OK: begin
				cw.out_load = 1'b1;
				cw.stat     = STAT_CONVERGED;
				cw.cond     = C_OUT_BUSY;
				cw.tgt      = ST_DONE_OK;
				cw.nxt      = ST_IDLE;
			end
			ST_DONE_LIM: begin
				cw.out_load = 1'b1;
				cw.stat     = STAT_LIMIT;
				cw.cond     = C_OUT_BUSY;
				cw.tgt      = ST_DONE_LIM;
				cw.nxt      = ST_IDLE;
			end
			default: begin
				cw.tgt = ST_IDLE;
				cw.nxt = ST_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/newton_square_root.sv -----
// Newton square root: microcoded sequencer around a shared restoring divider.
// Each Newton update runs a 32+FRAC_BITS step serial division, then the test, limit
// check and update steps; data words are Q16.16 at the default FRAC_BITS. One item at a time.
// The serial divider and output stalls set the rate; the result waits in an output register.
// Reset (arst_n low) idles the sequencer, drops out_valid and sets tolerance to 66.
`default_nettype none
module newton_square_root #(
	parameter int MAX_ITER  = nsr_pkg::MAX_ITER_DEF,
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_wr_en,
	input  wire logic [nsr_pkg::TOL_W-1:0]   cfg_wr_data,
	// input words
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [nsr_pkg::DATA_W-1:0]  radicand,
	// result words
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [nsr_pkg::DATA_W-1:0]       root,
	output logic                             status
);

	localparam int DW_   = nsr_pkg::DATA_W;
	localparam int DIV_W = DW_ + FRAC_BITS;      // dividend and quotient width
	localparam int EXT_W = DIV_W + 1;            // width for sums and compares
	localparam int CW    = $clog2(DIV_W);        // division step counter
	localparam int IW    = $clog2(MAX_ITER + 1); // update counter
	localparam logic [DW_-1:0] ONE = DW_'(1) << FRAC_BITS;

	// sequencer
	nsr_pkg::step_t pc_q, pc_d;
	nsr_pkg::ctrl_t cw;
	logic           cond_hit;

	// datapath registers
	logic [nsr_pkg::TOL_W-1:0] tol_q;
	logic [DW_-1:0]            rad_q;
	logic [DW_-1:0]            est_q;
	logic [IW-1:0]             iter_q;
	logic [DIV_W-1:0]          quot_q;
	logic [DW_-1:0]            rem_q;
	logic [CW-1:0]             dcnt_q;
	logic                      out_valid_q;
	logic [DW_-1:0]            root_q;
	logic                      status_q;

	// datapath nets
	logic [DW_:0]     trial;
	logic [DW_:0]     trial_sub;
	logic             trial_ge;
	logic [EXT_W-1:0] quot_ext, est_ext, tol_ext;
	logic             converged;
	logic             at_limit;
	logic [EXT_W-1:0] sum;
	logic [DIV_W-1:0] half;
	logic [DW_-1:0]   est_next;
	logic             out_free;
	logic             item_acc;

	assign cw       = nsr_pkg::ucode(pc_q);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (pc_q != nsr_pkg::ST_IDLE);
	assign item_acc = cw.ld_item && in_valid;

	// restoring division, one quotient bit per cycle
	assign trial     = {rem_q, quot_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, est_q};
	assign trial_ge  = (trial >= {1'b0, est_q});

	// stop test: |q - e| <= tol, written as two one-sided compares
	assign quot_ext  = {1'b0, quot_q};
	assign est_ext   = EXT_W'(est_q);
	assign tol_ext   = EXT_W'(tol_q);
	assign converged = (quot_ext <= est_ext + tol_ext) && (est_ext <= quot_ext + tol_ext);
	assign at_limit  = (iter_q >= IW'(MAX_ITER));

	// next estimate: half the sum, saturated, never zero
	assign sum  = est_ext + quot_ext;
	assign half = sum[EXT_W-1:1];
	always_comb begin
		if (|half[DIV_W-1:DW_]) begin
			est_next = '1;
		end else if (half[DW_-1:0] == '0) begin
			est_next = DW_'(1);
		end else begin
			est_next = half[DW_-1:0];
		end
	end

	// branch condition select
	always_comb begin
		unique case (cw.cond)
			nsr_pkg::C_ALWAYS:    cond_hit = 1'b1;
			nsr_pkg::C_NO_INPUT:  cond_hit = !in_valid;
			nsr_pkg::C_DIV_BUSY:  cond_hit = (dcnt_q != '0);
			nsr_pkg::C_CONVERGED: cond_hit = converged;
			nsr_pkg::C_AT_LIMIT:  cond_hit = at_limit;
			nsr_pkg::C_OUT_BUSY:  cond_hit = !out_free;
			default:              cond_hit = 1'b1;
		endcase
		pc_d = cond_hit ? cw.tgt : cw.nxt;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= nsr_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= nsr_pkg::TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (item_acc) begin
			iter_q <= '0;
		end else if (cw.est_upd) begin
			iter_q <= iter_q + IW'(1);
		end
	end

	// radicand, estimate and divider
	always_ff @(posedge clk) begin
		if (item_acc) begin
			rad_q <= radicand;
			est_q <= ONE;
		end
		if (cw.est_upd) begin
			est_q <= est_next;
		end
		if (cw.div_init) begin
			quot_q <= {rad_q, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			dcnt_q <= CW'(DIV_W - 1);
		end else if (cw.div_step) begin
			quot_q <= {quot_q[DIV_W-2:0], trial_ge};
			rem_q  <= trial_ge ? trial_sub[DW_-1:0] : trial[DW_-1:0];
			dcnt_q <= dcnt_q - CW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.out_load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_load && out_free) begin
			root_q   <= est_q;
			status_q <= cw.stat;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	// the divisor is never zero while an item is in progress
	a_est_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != nsr_pkg::ST_IDLE) |-> (est_q != '0))
		else $error("estimate is zero during an item");

	// a result appears only from a done step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(pc_q) == nsr_pkg::ST_DONE_OK ||
			$past(pc_q) == nsr_pkg::ST_DONE_LIM))
		else $error("result raised outside a done step");

	// update count never passes the cap
	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= IW'(MAX_ITER))
		else $error("iteration count above cap");

	// the test step is only reached after the last division step
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == nsr_pkg::ST_TEST) |-> ($past(pc_q) == nsr_pkg::ST_DIV_STEP &&
			$past(dcnt_q) == '0))
		else $error("test reached before division finished");
`endif

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Testbench for the Newton square root block: directed and random radicands checked against a predictor.
`default_nettype none
module testbench;

	localparam int ITER_CAP    = nsr_pkg::MAX_ITER_DEF;
	localparam int FRAC        = nsr_pkg::FRAC_BITS_DEF;
	localparam int SETTLE_CYC  = 8;
	localparam int TAIL_CYC    = 120;
	localparam int LONG_HOLD   = 5000;
	localparam longint RUN_CAP = 64'd800_000_000;

	localparam logic [nsr_pkg::DATA_W-1:0] ONE_Q = 32'h0001_0000;

	typedef struct packed {
		logic [nsr_pkg::DATA_W-1:0] root;
		logic                       status;
	} root_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [nsr_pkg::TOL_W-1:0]    cfg_wr_data;
	logic                         in_valid;
	logic                         in_stall;
	logic [nsr_pkg::DATA_W-1:0]   radicand;
	logic                         out_valid;
	logic                         out_stall;
	logic [nsr_pkg::DATA_W-1:0]   root;
	logic                         status;

	root_word_t                   pending_roots[$];
	logic [nsr_pkg::TOL_W-1:0]    tol_shadow = nsr_pkg::TOL_RESET;
	int                           words_taken = 0;
	int                           mismatch_count = 0;
	int                           burst_left = 0;
	int                           hold_asks = 0;

	newton_square_root #(
		.MAX_ITER  (ITER_CAP),
		.FRAC_BITS (FRAC)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.radicand    (radicand),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.root        (root),
		.status      (status)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Truncated Babylonian iteration from 1.0, exact 48-bit quotient
	function automatic root_word_t predict_root(input logic [nsr_pkg::DATA_W-1:0] value,
		input logic [nsr_pkg::TOL_W-1:0] tol);
		logic [63:0] scaled;
		logic [63:0] quot;
		logic [63:0] diff;
		logic [63:0] next;
		logic [nsr_pkg::DATA_W-1:0] est;
		int updates;
		bit done;
		root_word_t res;
		scaled = {32'b0, value} << FRAC;
		est = ONE_Q;
		updates = 0;
		done = 1'b0;
		res.status = nsr_pkg::STAT_CONVERGED;
		while (!done) begin
			quot = scaled / {32'b0, est};
			diff = (quot >= {32'b0, est}) ? quot - {32'b0, est} : {32'b0, est} - quot;
			if (diff <= {48'b0, tol}) begin
				done = 1'b1;
			end else if (updates >= ITER_CAP) begin
				res.status = nsr_pkg::STAT_LIMIT;
				done = 1'b1;
			end else begin
				next = ({32'b0, est} + quot) >> 1;
				if (next > 64'hFFFF_FFFF)
					next = 64'hFFFF_FFFF;
				if (next == 64'd0)
					next = 64'd1;
				est = next[nsr_pkg::DATA_W-1:0];
				updates++;
			end
		end
		res.root = est;
		return res;
	endfunction

	// Mix of full-range, shifted, small, exact squares and walking bits
	function automatic logic [nsr_pkg::DATA_W-1:0] random_radicand();
		logic [63:0] r;
		logic [nsr_pkg::DATA_W-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = $urandom >> $urandom_range(0, 31);
			3: v = $urandom_range(0, 65535);
			4: begin
				r = {40'b0, 16'($urandom_range(0, 65535)), 8'b0};
				v = 32'((r * r) >> FRAC);
			end
			default: begin
				v = 32'd1 << $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					v = ~v;
			end
		endcase
		return v;
	endfunction

	// Monitor: register writes, accepted radicands, and result check
	always @(posedge clk) begin
		root_word_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				tol_shadow = cfg_wr_data;
			if (in_valid && !in_stall) begin
				pending_roots.push_back(predict_root(radicand, tol_shadow));
				words_taken++;
			end
			if (out_valid && !out_stall) begin
				if (pending_roots.size() == 0) begin
					$error("result word with nothing pending: root %h status %b", root, status);
					mismatch_count++;
				end else begin
					want = pending_roots.pop_front();
					if (root !== want.root) begin
						$error("root mismatch: expected %h, actual %h", want.root, root);
						mismatch_count++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %b, actual %b", want.status, status);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Receiver: random stall modes, plus a long hold on request
	initial begin
		int holds_done;
		int hold_left;
		int mode;
		int mode_left;
		holds_done = 0;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks > holds_done) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 1) == 1);
					default: out_stall = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Hard stop for a hung run
	initial begin
		#(RUN_CAP);
		$display("Verification failed");
		$finish;
	end

	// Offer one word and hold it until taken; then maybe idle between bursts
	task automatic send_radicand(input logic [nsr_pkg::DATA_W-1:0] value);
		int seen;
		int gap;
		in_valid = 1'b1;
		radicand = value;
		seen = words_taken;
		do
			@(negedge clk);
		while (words_taken == seen);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 2))
				0: gap = 0;
				1: gap = $urandom_range(1, 8);
				default: gap = $urandom_range(1, 80);
			endcase
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Stop sending and wait for every pending result, then let the block go idle
	task automatic settle();
		in_valid = 1'b0;
		while (pending_roots.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_tolerance(input logic [nsr_pkg::TOL_W-1:0] tol);
		cfg_wr_en = 1'b1;
		cfg_wr_data = tol;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Corners at the reset tolerance
	task automatic test_reset_tolerance();
		logic [nsr_pkg::DATA_W-1:0] vals[13];
		vals = '{32'h0000_0000, 32'h0000_0001, ONE_Q, 32'h0004_0000, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0100,
			32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555};
		foreach (vals[i])
			send_radicand(vals[i]);
		settle();
	endtask

	// Zero tolerance (limit and zero-estimate floor), smallest nonzero and loosest
	task automatic test_tolerance_corners();
		logic [nsr_pkg::DATA_W-1:0] zero_tol[5];
		logic [nsr_pkg::DATA_W-1:0] tight_tol[3];
		logic [nsr_pkg::DATA_W-1:0] loose_tol[4];
		zero_tol = '{32'h0000_0000, 32'h0000_0001, ONE_Q, 32'hFFFF_FFFF, 32'h0002_0000};
		tight_tol = '{32'h0000_0002, 32'hFFFF_FFFF, 32'h0009_0000};
		loose_tol = '{32'h0000_0000, 32'hFFFF_FFFF, ONE_Q, 32'h0003_0000};
		write_tolerance(16'd0);
		foreach (zero_tol[i])
			send_radicand(zero_tol[i]);
		settle();
		write_tolerance(16'd1);
		foreach (tight_tol[i])
			send_radicand(tight_tol[i]);
		settle();
		write_tolerance(16'hFFFF);
		foreach (loose_tol[i])
			send_radicand(loose_tol[i]);
		settle();
	endtask

	// Random radicands over a sweep of tolerance settings
	task automatic test_random_radicands();
		logic [nsr_pkg::TOL_W-1:0] tols[8];
		int counts[8];
		tols = '{nsr_pkg::TOL_RESET, 16'($urandom_range(2, 200)), 16'd1,
			16'($urandom_range(1, 65535)), 16'hFFFF, 16'd0,
			16'($urandom_range(1, 16)), nsr_pkg::TOL_RESET};
		counts = '{150, 150, 140, 100, 100, 40, 150, 150};
		foreach (tols[p]) begin
			write_tolerance(tols[p]);
			repeat (counts[p])
				send_radicand(random_radicand());
			settle();
		end
	endtask

	// Long receiver hold while words keep coming, so the input stalls
	task automatic test_output_hold();
		write_tolerance(16'($urandom_range(1, 300)));
		hold_asks++;
		repeat (8)
			send_radicand(random_radicand());
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		radicand = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_tolerance();
		test_tolerance_corners();
		test_output_hold();
		test_random_radicands();

		settle();
		repeat (TAIL_CYC) @(negedge clk);
		if (mismatch_count == 0 && pending_roots.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/nsr_pkg.sv
hw/rtl/newton_square_root.sv
bench/testbench.sv
